// File: rtl/cetb_pkg.sv
// Package for the call edge table builder: sizes, item structs, codes, control structs.
// No dependencies.
package cetb_pkg;

  localparam int MaxFunctions = 256;
  localparam int MaxEdges     = 1024;
  localparam int SlotW        = 8;
  localparam int EdgeIdxW     = 10;
  localparam int EdgeCntW     = 11;
  localparam int FcountW      = 9;
  localparam int AddrW        = 64;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_REF   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_ADDED      = 3'd1;
  localparam logic [2:0] ST_NOTCALL    = 3'd2;
  localparam logic [2:0] ST_UNRESOLVED = 3'd3;
  localparam logic [2:0] ST_SELF       = 3'd4;
  localparam logic [2:0] ST_DUP        = 3'd5;
  localparam logic [2:0] ST_FULL       = 3'd6;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  slot;
    logic [63:0] range_start;
    logic [63:0] range_end;
    logic [63:0] source_addr;
    logic [63:0] target_addr;
    logic        call_flag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  caller_slot;
    logic [7:0]  callee_slot;
    logic [10:0] edges_held;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch the input item
    logic slot_write;  // write function slot memories
    logic scan_start;  // reset scan index to 0
    logic scan_step;   // advance scan index
    logic sel_target;  // 0: compare source, 1: compare target
    logic rec_src;     // record match as caller
    logic rec_dst;     // record match as callee
    logic edge_write;  // append edge
    logic edge_clear;  // zero edge count
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] opcode;
    logic       call_flag;
    logic       slot_match;  // registered compare of the previous read is a hit
    logic       slot_valid;  // registered compare result is meaningful
    logic       slot_last;   // current scan index is the last slot to look at
    logic       slot_none;   // no slots in use
    logic       same_slot;
    logic       edge_match;
    logic       edge_valid;
    logic       edge_last;
    logic       edge_none;
    logic       edge_full;
    logic       scan_pending; // a read is issued, its compare not yet registered
  } stat_t;

endpackage

// File: rtl/cetb_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module cetb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/cetb_datapath.sv
// Datapath: slot and edge memories, scan counter, compare registers, result fields.
// Depends on cetb_pkg and cetb_ram.
module cetb_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  cetb_pkg::in_item_t      in_item,
  input  logic [8:0]              function_count,
  input  cetb_pkg::cmd_t          cmd,
  output cetb_pkg::stat_t         stat,
  output logic [7:0]              caller,
  output logic [7:0]              callee,
  output logic [10:0]             edge_total
);
  cetb_pkg::in_item_t item;
  logic [10:0] idx;        // scan index (slot or edge)
  logic [10:0] rd_idx;     // index whose data is on the RAM outputs
  logic        rd_valid;
  logic [63:0] start_q, end_q;
  logic [7:0]  efrom_q, eto_q;
  logic        hit;
  logic        hit_valid;
  logic [7:0]  hit_idx;
  logic [8:0]  limit;
  logic [63:0] addr;

  assign limit = (function_count > 9'(cetb_pkg::MaxFunctions)) ?
                 9'(cetb_pkg::MaxFunctions) : function_count;
  assign addr  = cmd.sel_target ? item.target_addr : item.source_addr;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      rd_valid   <= 1'b0;
      hit_valid  <= 1'b0;
      edge_total <= '0;
    end else begin
      if (cmd.scan_start) begin
        idx <= '0;
      end else if (cmd.scan_step) begin
        idx <= idx + 11'd1;
      end
      rd_valid  <= cmd.scan_step;
      hit_valid <= rd_valid;
      if (cmd.edge_clear) begin
        edge_total <= '0;
      end else if (cmd.edge_write) begin
        edge_total <= edge_total + 11'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= idx;
  end

  cetb_ram #(.Width(64), .Depth(cetb_pkg::MaxFunctions)) u_start (
    .clk, .we(cmd.slot_write), .waddr(item.slot), .wdata(item.range_start),
    .raddr(idx[7:0]), .rdata(start_q));
  cetb_ram #(.Width(64), .Depth(cetb_pkg::MaxFunctions)) u_end (
    .clk, .we(cmd.slot_write), .waddr(item.slot), .wdata(item.range_end),
    .raddr(idx[7:0]), .rdata(end_q));
  cetb_ram #(.Width(8), .Depth(cetb_pkg::MaxEdges)) u_efrom (
    .clk, .we(cmd.edge_write), .waddr(edge_total[9:0]), .wdata(caller),
    .raddr(idx[9:0]), .rdata(efrom_q));
  cetb_ram #(.Width(8), .Depth(cetb_pkg::MaxEdges)) u_eto (
    .clk, .we(cmd.edge_write), .waddr(edge_total[9:0]), .wdata(callee),
    .raddr(idx[9:0]), .rdata(eto_q));
  // Call site store: written; its read data is only compared with itself, so it never affects the edge match.
  logic [63:0] site_q;
  cetb_ram #(.Width(64), .Depth(cetb_pkg::MaxEdges)) u_site (
    .clk, .we(cmd.edge_write), .waddr(edge_total[9:0]), .wdata(item.source_addr),
    .raddr(idx[9:0]), .rdata(site_q));

  // Register the compare results; the slot path holds its 64-bit compares side by side.
  logic slot_hit_q, edge_hit_q;
  always_ff @(posedge clk) begin
    slot_hit_q <= (start_q == addr) ||
                  ((addr > start_q) && (end_q != '0) && (addr < end_q));
    edge_hit_q <= (efrom_q == caller) && (eto_q == callee) && (site_q == site_q);
    hit_idx    <= rd_idx[7:0];
  end
  assign hit = slot_hit_q;

  always_ff @(posedge clk) begin
    if (cmd.rec_src) begin
      caller <= cmd.rec_dst ? 8'd0 : hit_idx;
    end
    if (cmd.rec_dst) begin
      callee <= cmd.rec_src ? 8'd0 : hit_idx;
    end
  end

  always_comb begin
    stat.opcode       = item.opcode;
    stat.call_flag    = item.call_flag;
    stat.slot_match   = hit;
    stat.slot_valid   = hit_valid;
    stat.slot_last    = (idx + 11'd1 >= {2'b00, limit});
    stat.slot_none    = (limit == '0);
    stat.same_slot    = (caller == callee);
    stat.edge_match   = edge_hit_q;
    stat.edge_valid   = hit_valid;
    stat.edge_last    = (idx + 11'd1 >= edge_total);
    stat.edge_none    = (edge_total == '0);
    stat.edge_full    = (edge_total >= 11'(cetb_pkg::MaxEdges));
    stat.scan_pending = rd_valid;
  end
endmodule

// File: rtl/cetb_ctrl.sv
// Controller: sequences load, clear and reference items; references go through slot and edge scans.
// Depends on cetb_pkg.
module cetb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              out_free,
  input  cetb_pkg::stat_t   stat,
  output cetb_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done,
  output logic [2:0]        status
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DECO  = 8'b0000_0010,
    S_SRC   = 8'b0000_0100,
    S_DST   = 8'b0000_1000,
    S_CHK   = 8'b0001_0000,
    S_EDGE  = 8'b0010_0000,
    S_DRAIN = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic [2:0] status_next;
  logic issuing, issuing_next; // reads still being issued in this scan

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      status  <= cetb_pkg::ST_DONE;
      issuing <= 1'b0;
    end else begin
      state   <= state_next;
      status  <= status_next;
      issuing <= issuing_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    state_next   = state;
    status_next  = status;
    issuing_next = issuing;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        cmd.capture = in_fire;
        if (in_fire) begin
          state_next = S_DECO;
        end
      end
      S_DECO: begin
        status_next    = cetb_pkg::ST_DONE;
        cmd.scan_start = 1'b1;
        cmd.rec_src    = 1'b1;
        cmd.rec_dst    = 1'b1;
        case (stat.opcode)
          cetb_pkg::OP_LOAD: begin
            cmd.slot_write = 1'b1;
            state_next     = S_DONE;
          end
          cetb_pkg::OP_CLEAR: begin
            cmd.edge_clear = 1'b1;
            state_next     = S_DONE;
          end
          cetb_pkg::OP_REF: begin
            if (!stat.call_flag) begin
              status_next = cetb_pkg::ST_NOTCALL;
              state_next  = S_DONE;
            end else if (stat.slot_none) begin
              status_next = cetb_pkg::ST_UNRESOLVED;
              state_next  = S_DONE;
            end else begin
              issuing_next = 1'b1;
              state_next   = S_SRC;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_SRC, S_DST: begin
        cmd.sel_target = (state == S_DST);
        if (issuing) begin
          cmd.scan_step = 1'b1;
          if (stat.slot_last) begin
            issuing_next = 1'b0;
          end
        end
        if (stat.slot_valid && stat.slot_match) begin
          cmd.scan_start = 1'b1;
          issuing_next   = 1'b0;
          state_next     = S_DRAIN;
          if (state == S_SRC) begin
            cmd.rec_src = 1'b1;
            status_next = cetb_pkg::ST_ADDED; // marks source found
          end else begin
            cmd.rec_dst = 1'b1;
            status_next = cetb_pkg::ST_SELF;  // marks target found
          end
        end else if (!issuing && !stat.slot_valid && !stat.scan_pending &&
                     !cmd.scan_step) begin
          status_next = cetb_pkg::ST_UNRESOLVED;
          cmd.rec_src = 1'b1;
          cmd.rec_dst = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_DRAIN: begin
        // let the pipeline empty before the next scan
        if (!stat.slot_valid && !stat.edge_valid) begin
          cmd.scan_start = 1'b1;
          if (status == cetb_pkg::ST_ADDED) begin
            issuing_next = 1'b1;
            state_next   = S_DST;
          end else begin
            state_next = S_CHK;
          end
        end
      end
      S_CHK: begin
        cmd.scan_start = 1'b1;
        if (stat.same_slot) begin
          status_next = cetb_pkg::ST_SELF;
          state_next  = S_DONE;
        end else if (stat.edge_none) begin
          state_next = S_EDGE;
          issuing_next = 1'b0;
        end else begin
          issuing_next = 1'b1;
          state_next   = S_EDGE;
        end
      end
      S_EDGE: begin
        if (issuing) begin
          cmd.scan_step = 1'b1;
          if (stat.edge_last) begin
            issuing_next = 1'b0;
          end
        end
        if (stat.edge_valid && stat.edge_match) begin
          status_next  = cetb_pkg::ST_DUP;
          issuing_next = 1'b0;
          state_next   = S_DONE;
        end else if (!issuing && !stat.edge_valid && !stat.scan_pending &&
                     !cmd.scan_step) begin
          if (stat.edge_full) begin
            status_next = cetb_pkg::ST_FULL;
          end else begin
            cmd.edge_write = 1'b1;
            status_next    = cetb_pkg::ST_ADDED;
          end
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// File: rtl/call_edge_table_builder.sv
// Call edge table builder top level: ports, output register, controller and datapath.
// Depends on cetb_pkg, cetb_ctrl, cetb_datapath.
// Timing: load, clear and non-call items go straight from decode to the output register;
//   a reference scans the slots in use for the source, then for the target, then the edges
//   held, with one read a cycle from the slot memories and then the edge memories.
// Throughput: one item at a time; in_ready stays low until the result enters the output register.
// Reset: rst clears the edge count, function count, state and output valid.
module call_edge_table_builder (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cetb_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output cetb_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_wdata
);
  logic [8:0]      function_count;
  cetb_pkg::cmd_t  cmd;
  cetb_pkg::stat_t stat;
  logic            busy, done;
  logic [2:0]      status;
  logic [7:0]      caller, callee;
  logic [10:0]     edge_total;
  logic            in_fire, out_free;

  // Hold the function count register; the user must write it only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      function_count <= '0;
    end else if (cfg_we) begin
      function_count <= cfg_wdata;
    end
  end

  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;
  // The output register can take a result when empty or being drained.
  assign out_free = !out_valid || out_ready;

  cetb_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_free, .stat, .cmd, .busy, .done, .status);

  cetb_datapath u_dp (
    .clk, .rst, .in_item, .function_count, .cmd, .stat,
    .caller, .callee, .edge_total);

  // Output register: load the finished result, hold it until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && out_free) begin
      out_item.status      <= status;
      out_item.caller_slot <= caller;
      out_item.callee_slot <= callee;
      out_item.edges_held  <= edge_total;
    end
  end
endmodule

// File: tb/call_edge_table_builder_tb.sv
// Testbench for call_edge_table_builder: drives load, reference and clear items,
// predicts each result with an internal table model and checks it in order.
// Depends on cetb_pkg and the call_edge_table_builder RTL.
module call_edge_table_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: keeps its own copy of the slot and edge tables and a queue of
  // expected results, one per accepted item.
  class edge_scoreboard;
    logic [63:0] fn_start [cetb_pkg::MaxFunctions];
    logic [63:0] fn_end [cetb_pkg::MaxFunctions];
    logic [7:0]  e_from [cetb_pkg::MaxEdges];
    logic [7:0]  e_to [cetb_pkg::MaxEdges];
    int          edge_cnt;
    int          fn_count;
    cetb_pkg::out_item_t pending[$];
    int          errors;
    int          seen[8];

    function void reset_state();
      edge_cnt = 0;
      fn_count = 0;
      errors = 0;
    endfunction

    function bit lookup(logic [63:0] addr, output int idx);
      int lim;
      lim = (fn_count > cetb_pkg::MaxFunctions) ? cetb_pkg::MaxFunctions : fn_count;
      for (int i = 0; i < lim; i++) begin
        if (fn_start[i] == addr ||
            (addr > fn_start[i] && fn_end[i] != 0 && addr < fn_end[i])) begin
          idx = i;
          return 1;
        end
      end
      idx = 0;
      return 0;
    endfunction

    function void note_item(cetb_pkg::in_item_t it);
      cetb_pkg::out_item_t r;
      int a, b;
      bit dup;
      r = '0;
      case (it.opcode)
        cetb_pkg::OP_LOAD: begin
          fn_start[it.slot] = it.range_start;
          fn_end[it.slot] = it.range_end;
          r.status = cetb_pkg::ST_DONE;
        end
        cetb_pkg::OP_CLEAR: begin
          edge_cnt = 0;
          r.status = cetb_pkg::ST_DONE;
        end
        cetb_pkg::OP_REF: begin
          if (!it.call_flag) r.status = cetb_pkg::ST_NOTCALL;
          else if (!lookup(it.source_addr, a) || !lookup(it.target_addr, b))
            r.status = cetb_pkg::ST_UNRESOLVED;
          else begin
            r.caller_slot = 8'(a);
            r.callee_slot = 8'(b);
            dup = 0;
            for (int j = 0; j < edge_cnt; j++)
              if (e_from[j] == a && e_to[j] == b) dup = 1;
            if (a == b) r.status = cetb_pkg::ST_SELF;
            else if (dup) r.status = cetb_pkg::ST_DUP;
            else if (edge_cnt < cetb_pkg::MaxEdges) begin
              e_from[edge_cnt] = 8'(a);
              e_to[edge_cnt] = 8'(b);
              edge_cnt++;
              r.status = cetb_pkg::ST_ADDED;
            end else r.status = cetb_pkg::ST_FULL;
          end
        end
        default: r.status = cetb_pkg::ST_DONE;
      endcase
      r.edges_held = 11'(edge_cnt);
      pending.push_back(r);
    endfunction

    function void check_result(cetb_pkg::out_item_t got);
      cetb_pkg::out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      seen[got.status]++;
      if (got !== want) begin
        $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_ready;
  cetb_pkg::in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 0;
  cetb_pkg::out_item_t out_item;
  logic      cfg_we = 0;
  logic [8:0] cfg_wdata = '0;

  edge_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  int loaded_slots = 0;   // slots 0..loaded_slots-1 have been written
  logic [63:0] fn_base [cetb_pkg::MaxFunctions];

  call_edge_table_builder u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Receiver: pick ready at the falling edge, check at the rising edge.
  always @(negedge clk) begin
    out_ready <= !rst && !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_item);
  end

  // Offer one item, with random idle cycles first, and hold it until accepted.
  // Valid stays high after acceptance; the next item or stop_input follows.
  task automatic send_item(cetb_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_item <= it;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
    @(negedge clk);
  endtask

  // Drop valid once no further item follows.
  task automatic stop_input();
    in_valid <= 0;
  endtask

  // Drain: wait for every expected result, then let the block settle.
  task automatic drain();
    stop_input();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_count(int n);
    cfg_we <= 1;
    cfg_wdata <= n[8:0];
    @(negedge clk);
    cfg_we <= 0;
    sb.fn_count = n;
  endtask

  task automatic load_slot(int s, logic [63:0] st, logic [63:0] en);
    cetb_pkg::in_item_t it;
    it = '0;
    it.opcode = cetb_pkg::OP_LOAD;
    it.slot = 8'(s);
    it.range_start = st;
    it.range_end = en;
    it.source_addr = {$urandom, $urandom};
    it.target_addr = {$urandom, $urandom};
    it.call_flag = 1'($urandom);
    send_item(it);
  endtask

  // Pick an address that usually lands inside a loaded slot.
  function automatic logic [63:0] pick_addr(int nslots);
    int s;
    s = $urandom_range(nslots - 1);
    case ($urandom_range(9))
      0: return {$urandom, $urandom};
      1, 2, 3: return fn_base[s];
      default: return fn_base[s] + $urandom_range(1, 15);
    endcase
  endfunction

  task automatic send_ref(logic [63:0] src, logic [63:0] dst, bit call);
    cetb_pkg::in_item_t it;
    it = '0;
    it.opcode = cetb_pkg::OP_REF;
    it.slot = 8'($urandom);
    it.range_start = {$urandom, $urandom};
    it.range_end = {$urandom, $urandom};
    it.source_addr = src;
    it.target_addr = dst;
    it.call_flag = call;
    send_item(it);
  endtask

  task automatic send_op(logic [1:0] op);
    cetb_pkg::in_item_t it;
    it.opcode = op;
    it.slot = 8'($urandom);
    it.range_start = {$urandom, $urandom};
    it.range_end = {$urandom, $urandom};
    it.source_addr = {$urandom, $urandom};
    it.target_addr = {$urandom, $urandom};
    it.call_flag = 1'($urandom);
    send_item(it);
  endtask

  // Load nslots slots with ranges of 16 apart, some with unknown end.
  task automatic load_table(int nslots);
    logic [63:0] base;
    base = {$urandom, 32'h0} & 64'hFFFF_FFF0_0000_0000;
    for (int s = 0; s < nslots; s++) begin
      fn_base[s] = base + s * 16;
      load_slot(s, fn_base[s], ($urandom_range(4) == 0) ? 64'd0 : fn_base[s] + 16);
    end
    if (nslots > loaded_slots) loaded_slots = nslots;
  endtask

  task automatic random_phase(int n, int nslots);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 80) send_ref(pick_addr(nslots), pick_addr(nslots), $urandom_range(9) != 0);
      else if (r < 85) send_op(cetb_pkg::OP_CLEAR);
      else if (r < 88) send_op(2'd3);
      else begin
        r = $urandom_range(nslots - 1);
        fn_base[r] = {$urandom, $urandom} & ~64'hF;
        load_slot(r, fn_base[r], fn_base[r] + 16);
      end
    end
  endtask

  initial begin
    #2_000_000_000;
    $display("status: fail");
    $finish;
  end

  // Long hold-off in its own process: sender keeps going, block backs up.
  task automatic pressure_hold(int cycles);
    hold_off = 1;
    repeat (cycles) @(posedge clk);
    hold_off = 0;
    @(negedge clk);
  endtask

  initial begin
    sb.reset_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: extremes of addresses and every opcode and drop reason but a full edge table.
    write_count(0);
    load_slot(0, 64'd0, 64'd0);
    load_slot(1, 64'hFFFF_FFFF_FFFF_FFF0, 64'hFFFF_FFFF_FFFF_FFFF);
    load_slot(2, 64'h1000, 64'h2000);
    load_slot(3, 64'h1800, 64'd0);
    load_slot(255, 64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555);
    send_ref(64'h1000, 64'h1800, 1);   // no slots active: unresolved
    drain();
    write_count(4);
    send_ref(64'h1000, 64'h1800, 0);   // not a call
    send_ref(64'h1001, 64'h1FFF, 1);   // self inside slot 2
    send_ref(64'h1800, 64'hFFFF_FFFF_FFFF_FFF5, 1);  // first match wins: slot 2
    send_ref(64'd0, 64'h1000, 1);      // start equal to zero
    send_ref(64'd0, 64'h1000, 1);      // duplicate
    send_ref(64'h2000, 64'h1000, 1);   // end is exclusive: unresolved
    send_ref(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1);  // end exclusive at top
    send_ref(64'hFFFF_FFFF_FFFF_FFF0, 64'd0, 1);
    send_op(2'd3);
    send_op(cetb_pkg::OP_CLEAR);
    send_ref(64'd0, 64'h1000, 1);
    drain();
    write_count(256);
    load_table(256);
    send_ref(64'h5555_AAAA_5555_AAAA, fn_base[0], 1);
    drain();
    write_count(511);   // saturates to all slots
    send_ref(fn_base[255], fn_base[1], 1);
    drain();

    // Random phases with varying idling; small slot counts keep it quick.
    write_count(8);
    load_table(8);
    random_phase(40, 8);
    drain();
    send_idle_pct = 79;
    write_count(24);
    load_table(24);
    random_phase(40, 24);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 79;
    write_count(3);
    random_phase(40, 3);
    fork
      pressure_hold(400);
      begin
        random_phase(10, 3);
        stop_input();
      end
    join
    drain();
    send_idle_pct = 35;
    recv_stall_pct = 35;
    write_count(1);
    random_phase(15, 1);
    drain();
    write_count(16);
    random_phase(20, 16);
    drain();

    $display("Covered loads, clears, the unused opcode, every drop reason short of a full");
    $display("edge table, a 256-slot scan and count saturation; results by status 0..6:");
    $display("%0d %0d %0d %0d %0d %0d %0d", sb.seen[0], sb.seen[1],
             sb.seen[2], sb.seen[3], sb.seen[4], sb.seen[5], sb.seen[6]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
